// ===== rtl/core/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsf_pkg
// Shared types and constants for the FIR smoothing filter: field widths,
// coefficient reset values, sequencer states and the MAC control group.
// ----------------------------------------------------------------------------
package fsf_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;

    // Coefficient register file
    localparam int NUM_COEF  = 8;
    localparam int CIDX_W    = 3;
    localparam int CFG_IDX_W = 4;

    // Default number of taps in use
    localparam int TAPS_DEF  = 8;

    // Q1.14 fixed point: fraction bits and one half of an output LSB
    localparam int FRAC_BITS = 14;
    localparam int HALF_LSB  = 8192;

    // Reset value of coefficient k: unity on tap 0, zero elsewhere
    function automatic logic signed [COEF_W-1:0] coef_reset(input int k);
        logic signed [COEF_W-1:0] val;
        val = '0;
        if (k == 0)
        begin
            val = COEF_W'(16384);
        end
        return val;
    endfunction

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } fsf_state_t;

    // Control group from the sequencer to the MAC unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

// ===== rtl/core/fsf_sample_if.sv =====
// ----------------------------------------------------------------------------
// fsf_sample_if
// Valid/ready channel that carries one signed ECG sample per item.
// ----------------------------------------------------------------------------
interface fsf_sample_if
    import fsf_pkg::*;
();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ===== rtl/core/fsf_filtered_if.sv =====
// ----------------------------------------------------------------------------
// fsf_filtered_if
// Valid/ready channel that carries one filtered sample per item.
// ----------------------------------------------------------------------------
interface fsf_filtered_if
    import fsf_pkg::*;
();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);

endinterface

// ===== rtl/core/fsf_mac.sv =====
// ----------------------------------------------------------------------------
// fsf_mac
// Shared multiply-accumulate unit: one registered 16x16 signed product per
// cycle when enabled, summed into a wide accumulator on the next cycle.
// ----------------------------------------------------------------------------
module fsf_mac
    import fsf_pkg::*;
#(
    parameter int ACC_W = PROD_W + 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] operand,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Register the product before it reaches the adder
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * operand;
        end
    end

    // Clear at the start of an item, then add one product per acc_en cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/core/fir_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// fir_smoothing_filter
// Direct-form FIR smoothing filter for signed 16-bit ECG samples with
// programmable Q1.14 coefficients, round half away from zero, saturation.
// ----------------------------------------------------------------------------
// Each sample item runs through the sequencer states in order: an idle
// state in which the sample is accepted and captured, one pass per tap
// through the single shared 16x16 multiplier, a drain state to add the last
// product, and a round state to round, saturate, load the output register
// and shift the delay line. The input is ready only while the sequencer is
// idle; the output register lets the next sample be taken while a finished
// result still waits, and the round step holds only if the previous result
// has not been taken yet. Coefficients are written through the plain write
// port (index 0 to 7, other indexes ignored); the user must write them only
// while idle, as the block itself does not enforce it. Coefficients at or
// above TAPS are stored but have no effect.
// ----------------------------------------------------------------------------
module fir_smoothing_filter
    import fsf_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    fsf_sample_if.sink             smp,
    fsf_filtered_if.source         flt,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    localparam int DLY_DEPTH  = (TAPS > 1) ? TAPS - 1 : 1;
    localparam int DLY_IDX_W  = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
    localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W      = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 0);
    localparam int RND_W      = ACC_W + 1;

    fsf_state_t state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             last_tap;

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic signed [SAMPLE_W-1:0] delay_reg [DLY_DEPTH];
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       finish;
    mac_ctrl_t                  mac_ctrl;

    logic [CIDX_W-1:0]          coef_idx;
    logic [DLY_IDX_W-1:0]       dly_idx;
    logic signed [COEF_W-1:0]   mac_coef;
    logic signed [SAMPLE_W-1:0] mac_operand;
    logic signed [ACC_W-1:0]    acc;

    logic signed [RND_W-1:0]    rnd_sum;
    logic signed [RND_W-1:0]    rnd_q;
    logic [RND_W-SAMPLE_W:0]    rnd_top;
    logic signed [SAMPLE_W-1:0] sat_val;

    // Handshake qualifiers
    assign in_fire  = smp.valid && smp.ready;
    assign out_free = !out_vld_reg || flt.ready;
    assign last_tap = (tap_reg == TAP_W'(TAPS - 1));

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp.valid)
                begin
                    state_next = ST_MAC;
                    tap_next   = '0;
                end
            end
            ST_MAC:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        smp.ready       = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_en = 1'b0;
        finish          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                smp.ready      = 1'b1;
                mac_ctrl.clear = 1'b1;
            end
            ST_MAC:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = (tap_reg != '0);
            end
            ST_DRAIN:
            begin
                mac_ctrl.acc_en = 1'b1;
            end
            ST_ROUND:
            begin
                finish = out_free;
            end
            default:
            begin
                smp.ready = 1'b0;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    // Write coefficient registers; drop indexes beyond the file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= coef_reset(k);
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEF)))
        begin
            coef_reg[cfg_index[CIDX_W-1:0]] <= cfg_data;
        end
    end

    // Capture the new sample
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= smp.sample;
        end
    end

    // Shift the sample into the delay line as the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DLY_DEPTH; k++)
            begin
                delay_reg[k] <= '0;
            end
        end
        else if (finish)
        begin
            delay_reg[0] <= sample_reg;
            for (int k = 1; k < DLY_DEPTH; k++)
            begin
                delay_reg[k] <= delay_reg[k-1];
            end
        end
    end

    // Select the operands of the current tap
    assign coef_idx    = CIDX_W'(tap_reg);
    assign dly_idx     = DLY_IDX_W'(tap_reg - 1'b1);
    assign mac_coef    = coef_reg[coef_idx];
    assign mac_operand = (tap_reg == '0) ? sample_reg : delay_reg[dly_idx];

    fsf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .acc     (acc)
    );

    // Round half away from zero: add one half, less one on negative sums
    always_comb
    begin
        rnd_sum = RND_W'(acc) + RND_W'(HALF_LSB) - RND_W'(acc[ACC_W-1]);
        rnd_q   = rnd_sum >>> FRAC_BITS;
        rnd_top = rnd_q[RND_W-1:SAMPLE_W-1];
        if ((&rnd_top) || !(|rnd_top))
        begin
            sat_val = rnd_q[SAMPLE_W-1:0];
        end
        else if (rnd_q[RND_W-1])
        begin
            sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (flt.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            filtered_reg <= sat_val;
        end
    end

    assign flt.valid    = out_vld_reg;
    assign flt.filtered = filtered_reg;

    // An accepted item starts the tap sweep at tap 0
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MAC) && (tap_reg == '0))
        else $error("tap sweep did not start after an accepted item");

    // The last tap hands over to the final accumulate
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) && last_tap |=> (state_reg == ST_DRAIN))
        else $error("sequencer skipped the final accumulate");

    // A new result appears only out of the round step
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(state_reg) == ST_ROUND))
        else $error("result loaded outside the round step");

    // No new item is taken while the sequencer is in the drain state
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !smp.ready)
        else $error("input ready while an item is in progress");

endmodule
